@@ design/virtqueue_descriptor_ring_manager_assert.svh @@
// Assertion macros for the descriptor ring manager.
// Each macro is empty when SYNTHESIS is defined.
`ifndef VIRTQUEUE_DESCRIPTOR_RING_MANAGER_ASSERT_SVH
`define VIRTQUEUE_DESCRIPTOR_RING_MANAGER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define VDRM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vdrm assertion failed");

// Check that a condition leads to a consequence on the following clock.
`define VDRM_ASSERT_NEXT(lbl, clk, rst_n, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("vdrm assertion failed");

`else

`define VDRM_ASSERT(lbl, clk, rst_n, prop)
`define VDRM_ASSERT_NEXT(lbl, clk, rst_n, cause, effect)

`endif

`endif

@@ design/vdrm_pkg.sv @@
package vdrm_pkg;

    // Operation codes carried on s_tuser.
    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_POST = 2'd1;
    localparam logic [1:0] FUNC_TAKE = 2'd2;
    localparam logic [1:0] FUNC_KICK = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NO_USED  = 2'd2;
    localparam logic [1:0] ST_BAD_ID   = 2'd3;

    // Fixed field widths.
    localparam int CHAIN_W   = 9;
    localparam int ADDR_W    = 64;
    localparam int LEN_W     = 32;
    localparam int ID_W      = 16;
    localparam int RING_IX_W = 16;
    localparam int COUNT_W   = 9;

    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 128;

endpackage

@@ design/vdrm_ram.sv @@
module vdrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/virtqueue_descriptor_ring_manager.sv @@
// Driver side of a split virtqueue: a descriptor table whose free entries form
// a linked list, plus a used ring that the host fills. One item enters on the
// s_ side (operation in s_tuser) and exactly one result leaves on the m_ side.
// After reset the block sweeps the descriptor table once, one entry per clock,
// and takes no item meanwhile (configuration writes are taken at any time).
// Per item: a kick, a host post, a refused add or a take with no used entry
// go straight to the result state; an accepted add segment first reads the
// free-list link, then writes the table; a take of a used entry reads the used
// ring, then either consumes an out-of-range id at once or walks the reclaimed
// chain one descriptor per clock through the table's single read port.
// The next item is accepted while a result still waits on the m_ side.
`include "virtqueue_descriptor_ring_manager_assert.svh"

module virtqueue_descriptor_ring_manager
    import vdrm_pkg::*;
#(
    parameter int QUEUE_SIZE = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration: bit 0 suppresses used-event index updates.
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    // s_tdata, low bit up: chain_count[9], seg_addr[64], seg_len[32],
    // seg_device_writes[1], used_head_id[16], used_len[32], host_no_notify[1],
    // zero fill
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: func[2]
    input  logic [1:0]          s_tuser,
    // m_tdata, low bit up: status[2], buf_addr[64], buf_len[32],
    // free_count[9], notify[1], used_event_index[16], zero fill
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IW = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
    localparam int FW = $clog2(QUEUE_SIZE + 1);
    localparam int XW = (FW > CHAIN_W) ? FW : CHAIN_W;
    localparam logic [IW-1:0] LAST_IX = IW'(QUEUE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_WR,
        S_TK_ID,
        S_TK_WALK,
        S_DONE
    } state_t;

    // Input fields
    logic [CHAIN_W-1:0] in_chain_count;
    logic [ADDR_W-1:0]  in_seg_addr;
    logic [ID_W-1:0]    in_used_head_id;
    logic [LEN_W-1:0]   in_used_len;
    logic               in_host_no_notify;

    assign in_chain_count    = s_tdata[8:0];
    assign in_seg_addr       = s_tdata[72:9];
    assign in_used_head_id   = s_tdata[121:106];
    assign in_used_len       = s_tdata[153:122];
    assign in_host_no_notify = s_tdata[154];

    state_t               state_reg, state_next;
    logic [IW-1:0]        clr_idx_reg, clr_idx_next;
    logic                 irq_supp_reg, irq_supp_next;
    logic [IW-1:0]        free_head_reg, free_head_next;
    logic [IW-1:0]        free_tail_reg, free_tail_next;
    logic [FW-1:0]        free_total_reg, free_total_next;
    logic [FW-1:0]        seg_left_reg, seg_left_next;
    logic [RING_IX_W-1:0] used_index_reg, used_index_next;
    logic [IW-1:0]        used_pos_reg, used_pos_next;
    logic [RING_IX_W-1:0] seen_reg, seen_next;
    logic [IW-1:0]        seen_pos_reg, seen_pos_next;
    logic [RING_IX_W-1:0] used_event_reg, used_event_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        id_reg, id_next;
    logic [FW-1:0]        steps_reg, steps_next;
    logic [ADDR_W-1:0]    seg_addr_reg, seg_addr_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [LEN_W-1:0]     res_len_reg, res_len_next;
    logic                 res_notify_reg, res_notify_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Memory ports
    logic                  addr_we, addr_re;
    logic [IW-1:0]         addr_wa, addr_ra;
    logic [ADDR_W-1:0]     addr_wd, addr_rd;
    logic                  flag_we, flag_re;
    logic [IW-1:0]         flag_wa, flag_ra;
    logic                  flag_wd, flag_rd;
    logic                  link_we, link_re;
    logic [IW-1:0]         link_wa, link_ra;
    logic [IW-1:0]         link_wd, link_rd;
    logic                  used_we, used_re;
    logic [IW-1:0]         used_wa, used_ra;
    logic [ID_W+LEN_W-1:0] used_wd, used_rd;

    logic            s_accept;
    logic [XW-1:0]   chain_ext, total_ext;
    logic [FW:0]     total_sum;
    logic [ID_W:0]   id_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign chain_ext = XW'(in_chain_count);
    assign total_ext = XW'(free_total_reg);
    assign total_sum = {1'b0, free_total_reg} + {1'b0, steps_reg};
    assign id_ext    = {1'b0, used_rd[ID_W-1:0]};

    vdrm_ram #(.WIDTH(ADDR_W), .DEPTH(QUEUE_SIZE)) u_addr_ram (
        .aclk(aclk), .wr_en(addr_we), .wr_addr(addr_wa), .wr_data(addr_wd),
        .rd_en(addr_re), .rd_addr(addr_ra), .rd_data(addr_rd)
    );

    vdrm_ram #(.WIDTH(1), .DEPTH(QUEUE_SIZE)) u_flag_ram (
        .aclk(aclk), .wr_en(flag_we), .wr_addr(flag_wa), .wr_data(flag_wd),
        .rd_en(flag_re), .rd_addr(flag_ra), .rd_data(flag_rd)
    );

    vdrm_ram #(.WIDTH(IW), .DEPTH(QUEUE_SIZE)) u_link_ram (
        .aclk(aclk), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
        .rd_en(link_re), .rd_addr(link_ra), .rd_data(link_rd)
    );

    vdrm_ram #(.WIDTH(ID_W + LEN_W), .DEPTH(QUEUE_SIZE)) u_used_ram (
        .aclk(aclk), .wr_en(used_we), .wr_addr(used_wa), .wr_data(used_wd),
        .rd_en(used_re), .rd_addr(used_ra), .rd_data(used_rd)
    );

    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        irq_supp_next   = cfg_wr_en ? cfg_wr_data : irq_supp_reg;
        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        free_total_next = free_total_reg;
        seg_left_next   = seg_left_reg;
        used_index_next = used_index_reg;
        used_pos_next   = used_pos_reg;
        seen_next       = seen_reg;
        seen_pos_next   = seen_pos_reg;
        used_event_next = used_event_reg;
        cur_next        = cur_reg;
        id_next         = id_reg;
        steps_next      = steps_reg;
        seg_addr_next   = seg_addr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_len_next    = res_len_reg;
        res_notify_next = res_notify_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        addr_we = 1'b0; addr_wa = cur_reg; addr_wd = '0;
        addr_re = 1'b0; addr_ra = cur_reg;
        flag_we = 1'b0; flag_wa = free_head_reg; flag_wd = 1'b0;
        flag_re = 1'b0; flag_ra = cur_reg;
        link_we = 1'b0; link_wa = free_tail_reg; link_wd = id_reg;
        link_re = 1'b0; link_ra = cur_reg;
        used_we = 1'b0; used_wa = used_pos_reg;
        used_wd = {in_used_len, in_used_head_id};
        used_re = 1'b0; used_ra = seen_pos_reg;

        unique case (state_reg)
            S_CLEAR: begin
                // Sweep the table to its reset contents: empty, linked in order.
                addr_we = 1'b1;
                addr_wa = clr_idx_reg;
                flag_we = 1'b1;
                flag_wa = clr_idx_reg;
                link_we = 1'b1;
                link_wa = clr_idx_reg;
                link_wd = (clr_idx_reg == LAST_IX) ? '0 : clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IX) begin
                    state_next = S_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_accept) begin
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_len_next    = '0;
                    res_notify_next = 1'b0;
                    state_next      = S_DONE;
                    unique case (s_tuser)
                        FUNC_ADD: begin
                            if (seg_left_reg == '0 &&
                                (chain_ext == '0 || chain_ext > total_ext)) begin
                                // Refuse the chain; nothing changes.
                                res_status_next = ST_NO_SPACE;
                            end else begin
                                if (seg_left_reg == '0) begin
                                    free_total_next = free_total_reg - FW'(in_chain_count);
                                    seg_left_next   = FW'(in_chain_count) - 1'b1;
                                end else begin
                                    seg_left_next = seg_left_reg - 1'b1;
                                end
                                // Fetch the successor of the free-list head.
                                link_re       = 1'b1;
                                link_ra       = free_head_reg;
                                seg_addr_next = in_seg_addr;
                                state_next    = S_ADD_WR;
                            end
                        end
                        FUNC_POST: begin
                            used_we         = 1'b1;
                            used_index_next = used_index_reg + 1'b1;
                            if (used_index_reg == '1 || used_pos_reg == LAST_IX) begin
                                used_pos_next = '0;
                            end else begin
                                used_pos_next = used_pos_reg + 1'b1;
                            end
                        end
                        FUNC_TAKE: begin
                            if (seen_reg == used_index_reg) begin
                                res_status_next = ST_NO_USED;
                            end else begin
                                used_re    = 1'b1;
                                state_next = S_TK_ID;
                            end
                        end
                        FUNC_KICK: begin
                            res_notify_next = !in_host_no_notify;
                        end
                        default: ;
                    endcase
                end
            end

            S_ADD_WR: begin
                // Fill the head descriptor and advance the free list.
                addr_we        = 1'b1;
                addr_wa        = free_head_reg;
                addr_wd        = seg_addr_reg;
                flag_we        = 1'b1;
                flag_wa        = free_head_reg;
                flag_wd        = (seg_left_reg != '0);
                free_head_next = link_rd;
                state_next     = S_DONE;
            end

            S_TK_ID: begin
                if (id_ext >= (ID_W + 1)'(QUEUE_SIZE)) begin
                    // Consume the entry but free nothing.
                    res_status_next = ST_BAD_ID;
                    seen_next       = seen_reg + 1'b1;
                    seen_pos_next   = (seen_reg == '1 || seen_pos_reg == LAST_IX) ?
                                      '0 : seen_pos_reg + 1'b1;
                    if (!irq_supp_reg) begin
                        used_event_next = seen_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end else begin
                    res_len_next = used_rd[ID_W+LEN_W-1:ID_W];
                    id_next      = used_rd[IW-1:0];
                    cur_next     = used_rd[IW-1:0];
                    steps_next   = FW'(1);
                    addr_re      = 1'b1;
                    addr_ra      = used_rd[IW-1:0];
                    flag_re      = 1'b1;
                    flag_ra      = used_rd[IW-1:0];
                    link_re      = 1'b1;
                    link_ra      = used_rd[IW-1:0];
                    state_next   = S_TK_WALK;
                end
            end

            S_TK_WALK: begin
                if (steps_reg == FW'(1)) begin
                    res_addr_next = addr_rd;
                end
                // Clear the address of the descriptor under the cursor.
                addr_we = 1'b1;
                addr_wa = cur_reg;
                if (flag_rd && steps_reg < FW'(QUEUE_SIZE)) begin
                    cur_next   = link_rd;
                    steps_next = steps_reg + 1'b1;
                    addr_re    = 1'b1;
                    addr_ra    = link_rd;
                    flag_re    = 1'b1;
                    flag_ra    = link_rd;
                    link_re    = 1'b1;
                    link_ra    = link_rd;
                end else begin
                    // Append the chain to the free list.
                    if (free_total_reg == '0) begin
                        free_head_next = id_reg;
                    end else begin
                        link_we = 1'b1;
                    end
                    free_tail_next  = cur_reg;
                    free_total_next = (total_sum > (FW + 1)'(QUEUE_SIZE)) ?
                                      FW'(QUEUE_SIZE) : total_sum[FW-1:0];
                    seen_next       = seen_reg + 1'b1;
                    seen_pos_next   = (seen_reg == '1 || seen_pos_reg == LAST_IX) ?
                                      '0 : seen_pos_reg + 1'b1;
                    if (!irq_supp_reg) begin
                        used_event_next = seen_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                // Hold the result until the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, used_event_reg, res_notify_reg,
                                     COUNT_W'(free_total_reg), res_len_reg,
                                     res_addr_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            irq_supp_reg   <= 1'b0;
            free_head_reg  <= '0;
            free_tail_reg  <= LAST_IX;
            free_total_reg <= FW'(QUEUE_SIZE);
            seg_left_reg   <= '0;
            used_index_reg <= '0;
            used_pos_reg   <= '0;
            seen_reg       <= '0;
            seen_pos_reg   <= '0;
            used_event_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            irq_supp_reg   <= irq_supp_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            free_total_reg <= free_total_next;
            seg_left_reg   <= seg_left_next;
            used_index_reg <= used_index_next;
            used_pos_reg   <= used_pos_next;
            seen_reg       <= seen_next;
            seen_pos_reg   <= seen_pos_next;
            used_event_reg <= used_event_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        cur_reg        <= cur_next;
        id_reg         <= id_next;
        steps_reg      <= steps_next;
        seg_addr_reg   <= seg_addr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_len_reg    <= res_len_next;
        res_notify_reg <= res_notify_next;
        m_tdata_reg    <= m_tdata_next;
    end

    `VDRM_ASSERT(a_free_total_bound, aclk, aresetn, free_total_reg <= FW'(QUEUE_SIZE))
    `VDRM_ASSERT(a_walk_bound, aclk, aresetn,
        !(state_reg == S_TK_WALK) || (steps_reg <= FW'(QUEUE_SIZE)))
    `VDRM_ASSERT_NEXT(a_empty_chain_refused, aclk, aresetn,
        s_accept && s_tuser == FUNC_ADD && seg_left_reg == '0 && in_chain_count == '0,
        $stable(free_total_reg) && res_status_reg == ST_NO_SPACE)

endmodule
